### rtl/awadm_pkg.sv
// shared types, constants and bound tables for the window average block
package awadm_pkg;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int CH_W      = 4;
  localparam int MAP_W     = 15;
  localparam int SHIFT_W   = 3;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SHIFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_MASK = 2'd1;

  // register reset values
  localparam logic [SHIFT_W-1:0] WINDOW_SHIFT_RST   = 3'd7;
  localparam logic [MASK_W-1:0]  DIRECTION_MASK_RST = 16'hF8FF;

  // input action codes
  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_CLOSE  = 1'b1;

  // top of the output scale
  localparam logic [MAP_W-1:0] FULL_SCALE = 15'd16384;

  // reciprocal scaling: q = (span * recip) >> RECIP_SHIFT, recip = ceil(2^46 / (high - low));
  // exact floor of span * 16384 / (high - low) since span * 16384 stays below 2^30
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 32;

  localparam logic [RECIP_W-1:0] RECIP_65000 = 31'(((64'd1 << 46) + 64'd64999) / 64'd65000);
  localparam logic [RECIP_W-1:0] RECIP_65300 = 31'(((64'd1 << 46) + 64'd65299) / 64'd65300);
  localparam logic [RECIP_W-1:0] RECIP_61500 = 31'(((64'd1 << 46) + 64'd61499) / 64'd61500);
  localparam logic [RECIP_W-1:0] RECIP_61484 = 31'(((64'd1 << 46) + 64'd61483) / 64'd61484);
  localparam logic [RECIP_W-1:0] RECIP_61000 = 31'(((64'd1 << 46) + 64'd60999) / 64'd61000);
  localparam logic [RECIP_W-1:0] RECIP_65053 = 31'(((64'd1 << 46) + 64'd65052) / 64'd65053);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                close;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } awadm_item_t;

  typedef struct packed {
    logic        push;
    awadm_item_t item;
  } awadm_push_t;

  typedef struct packed {
    logic        valid;
    awadm_item_t item;
  } awadm_head_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] window_shift;
    logic [MASK_W-1:0]  direction_mask;
  } awadm_cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [MAP_W-1:0] mapped_value;
    logic             changed;
    logic             last;
  } awadm_result_t;

  // per-channel deadband
  function automatic logic [15:0] deadband(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd6, 4'd7, 4'd11, 4'd12, 4'd13: v = 16'd75;
      default:                         v = 16'd50;
    endcase
    return v;
  endfunction

  // per-channel lower clamp
  function automatic logic [15:0] low_bound(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd8, 4'd9, 4'd10: v = 16'd200;
      4'd12:             v = 16'd516;
      4'd13:             v = 16'd1000;
      4'd14, 4'd15:      v = 16'd450;
      default:           v = 16'd500;
    endcase
    return v;
  endfunction

  // per-channel upper clamp
  function automatic logic [15:0] high_bound(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd11, 4'd12, 4'd13: v = 16'd62000;
      4'd14, 4'd15:        v = 16'd65503;
      default:             v = 16'd65500;
    endcase
    return v;
  endfunction

  // per-channel reciprocal of the bound span
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] idx);
    logic [RECIP_W-1:0] v;
    case (idx)
      4'd8, 4'd9, 4'd10: v = RECIP_65300;
      4'd11:             v = RECIP_61500;
      4'd12:             v = RECIP_61484;
      4'd13:             v = RECIP_61000;
      4'd14, 4'd15:      v = RECIP_65053;
      default:           v = RECIP_65000;
    endcase
    return v;
  endfunction

endpackage

### rtl/awadm_front.sv
// front end: takes input requests, drops out-of-range samples, feeds the queue
module awadm_front #(
  parameter int CHANNELS = 16
) (
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic                       in_action,
  input  logic [awadm_pkg::CH_W-1:0] in_channel,
  input  logic [15:0]                in_sample,
  input  logic                       queue_full,
  output awadm_pkg::awadm_push_t     push
);
  import awadm_pkg::*;

  logic accept;
  logic in_range;

  // accept whenever the queue has room
  assign in_tready = !queue_full;
  assign accept    = in_tvalid && in_tready;

  // a sample for a channel that does not exist is accepted and dropped
  assign in_range = int'(in_channel) < CHANNELS;

  always_comb begin
    push.push         = accept && ((in_action == ACTION_CLOSE) || in_range);
    push.item.close   = (in_action == ACTION_CLOSE);
    push.item.channel = in_channel;
    push.item.sample  = in_sample;
  end

endmodule

### rtl/awadm_queue.sv
// short request queue decoupling front and back
module awadm_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  awadm_pkg::awadm_push_t push,
  output logic                   full,
  output awadm_pkg::awadm_head_t head,
  input  logic                   pop
);
  import awadm_pkg::*;

  awadm_item_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rptr_r];

  assign do_push = push.push && !full;
  assign do_pop  = pop && head.valid;

  // pointer and fill count update
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push.item;
    end
  end

endmodule

### rtl/awadm_back.sv
// back end: accumulates samples, runs the per-channel close sequence with a reciprocal multiply
module awadm_back #(
  parameter int CHANNELS = 16,
  parameter int ACC_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  awadm_pkg::awadm_cfg_t    cfg,
  input  awadm_pkg::awadm_head_t   head,
  output logic                     pop,
  output logic                     res_valid,
  output awadm_pkg::awadm_result_t res,
  input  logic                     res_ready
);
  import awadm_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);
  localparam int KW = SAMPLE_W + MAP_W;
  localparam int PW = SAMPLE_W + RECIP_W;

  // sequencer codes
  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_CREAD = 3'd1;
  localparam logic [2:0] ST_CEVAL = 3'd2;
  localparam logic [2:0] ST_CMUL  = 3'd3;
  localparam logic [2:0] ST_CEMIT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // accumulator memory, cleared through per-channel valid bits
  logic [ACC_BITS-1:0] acc_mem [CHANNELS];
  logic [ACC_BITS-1:0] acc_rdata_r;
  logic [CW-1:0]       acc_raddr;
  logic [CHANNELS-1:0] acc_vld_r, acc_vld_nxt;

  // kept average and mapped value memory
  logic [KW-1:0]       kept_mem [CHANNELS];
  logic [KW-1:0]       kept_rdata_r;
  logic                kept_we;
  logic [CHANNELS-1:0] kept_vld_r, kept_vld_nxt;

  // sample pipeline
  logic                s2_v_r;
  logic [CW-1:0]       s2_addr_r;
  logic [SAMPLE_W-1:0] s2_sample_r;
  logic                fwd_r, fwd_nxt;
  logic [ACC_BITS-1:0] fwd_data_r;
  logic [ACC_BITS-1:0] s2_base;
  logic [ACC_BITS-1:0] s2_sum;
  logic [CW+3:0]       pop_ch_ext;
  logic [CW-1:0]       pop_addr;
  logic                pop_sample;
  logic                pop_close;

  // close evaluation
  logic [CW+3:0]       cnt_ext;
  logic [3:0]          tab;
  logic [ACC_BITS-1:0] acc_cur;
  logic [ACC_BITS-1:0] acc_shifted;
  logic [15:0]         avg;
  logic [KW-1:0]       kept_cur;
  logic [15:0]         db;
  logic [15:0]         lo_b;
  logic [15:0]         hi_b;
  logic signed [17:0]  lim_lo;
  logic signed [17:0]  lim_hi;
  logic signed [17:0]  avg_s;
  logic                chg;
  logic                degen;
  logic [15:0]         clamped;

  logic [15:0]        avg_r;
  logic               chg_r;
  logic [MAP_W-1:0]   kept_map_r;
  logic               dir_r;
  logic [15:0]        span_r, span_nxt;
  logic [RECIP_W-1:0] recip_r;
  logic [MAP_W-1:0]   quo_r, quo_nxt;
  logic [PW-1:0]      prod;

  // result register
  logic              out_v_r, out_v_nxt;
  awadm_result_t     out_r;
  logic              emit;
  logic [MAP_W-1:0]  new_map;
  logic [MAP_W-1:0]  res_map;

  // pop only in the run state; a close stops the flow until its run is done
  assign pop        = (state_r == ST_RUN) && head.valid;
  assign pop_sample = pop && (head.item.close == ACTION_SAMPLE);
  assign pop_close  = pop && (head.item.close == ACTION_CLOSE);
  assign pop_ch_ext = {{CW{1'b0}}, head.item.channel};
  assign pop_addr   = pop_ch_ext[CW-1:0];

  assign acc_raddr = (state_r == ST_RUN) ? pop_addr : cnt_r;

  // second sample stage: forward the previous write when it hits the same channel
  assign s2_base = fwd_r ? fwd_data_r : (acc_vld_r[s2_addr_r] ? acc_rdata_r : '0);
  assign s2_sum  = s2_base + ACC_BITS'(s2_sample_r);
  assign fwd_nxt = s2_v_r && pop_sample && (pop_addr == s2_addr_r);

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_mem[s2_addr_r] <= s2_sum;
    end
    acc_rdata_r <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (kept_we) begin
      kept_mem[cnt_r] <= {avg_r, res_map};
    end
    kept_rdata_r <= kept_mem[cnt_r];
  end

  // close evaluation of the current channel
  assign cnt_ext     = {4'b0000, cnt_r};
  assign tab         = cnt_ext[3:0];
  assign acc_cur     = acc_vld_r[cnt_r] ? acc_rdata_r : '0;
  assign acc_shifted = acc_cur >> cfg.window_shift;
  assign avg         = acc_shifted[15:0];
  assign kept_cur    = kept_vld_r[cnt_r] ? kept_rdata_r : '0;
  assign db          = deadband(tab);
  assign lo_b        = low_bound(tab);
  assign hi_b        = high_bound(tab);
  assign avg_s       = $signed({2'b00, avg});
  assign lim_lo      = $signed({2'b00, kept_cur[KW-1:MAP_W]}) - $signed({2'b00, db});
  assign lim_hi      = $signed({2'b00, kept_cur[KW-1:MAP_W]}) + $signed({2'b00, db});
  assign chg         = (avg_s <= lim_lo) || (avg_s >= lim_hi);
  assign degen       = (hi_b <= lo_b);

  // clamp to the channel bounds
  always_comb begin
    clamped = avg;
    if (clamped < lo_b) begin
      clamped = lo_b;
    end
    if (clamped > hi_b) begin
      clamped = hi_b;
    end
  end

  // scaling by the channel's reciprocal span
  assign prod = span_r * recip_r;

  // final mapping and result selection
  assign new_map = dir_r ? quo_r : FULL_SCALE - quo_r;
  assign res_map = chg_r ? new_map : kept_map_r;
  assign emit    = (state_r == ST_CEMIT) && (!out_v_r || res_ready);
  assign kept_we = emit && chg_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    span_nxt  = span_r;
    quo_nxt   = quo_r;
    case (state_r)
      ST_RUN: begin
        if (pop_close) begin
          state_nxt = ST_CREAD;
          cnt_nxt   = '0;
        end
      end
      ST_CREAD: begin
        state_nxt = ST_CEVAL;
      end
      ST_CEVAL: begin
        span_nxt  = hi_b - clamped;
        quo_nxt   = '0;
        state_nxt = (chg && !degen) ? ST_CMUL : ST_CEMIT;
      end
      ST_CMUL: begin
        quo_nxt   = prod[RECIP_SHIFT +: MAP_W];
        state_nxt = ST_CEMIT;
      end
      ST_CEMIT: begin
        if (emit) begin
          if (cnt_r == LAST_CH) begin
            state_nxt = ST_RUN;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_CREAD;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // valid bits: samples mark, close clears, kept entries mark on update
  always_comb begin
    acc_vld_nxt  = acc_vld_r;
    kept_vld_nxt = kept_vld_r;
    if (s2_v_r) begin
      acc_vld_nxt[s2_addr_r] = 1'b1;
    end
    if (emit) begin
      acc_vld_nxt[cnt_r] = 1'b0;
    end
    if (kept_we) begin
      kept_vld_nxt[cnt_r] = 1'b1;
    end
  end

  // output register handshake
  always_comb begin
    out_v_nxt = out_v_r;
    if (res_ready) begin
      out_v_nxt = 1'b0;
    end
    if (emit) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      cnt_r      <= '0;
      acc_vld_r  <= '0;
      kept_vld_r <= '0;
      s2_v_r     <= 1'b0;
      fwd_r      <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      acc_vld_r  <= acc_vld_nxt;
      kept_vld_r <= kept_vld_nxt;
      s2_v_r     <= pop_sample;
      fwd_r      <= fwd_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s2_addr_r   <= pop_addr;
    s2_sample_r <= head.item.sample;
    fwd_data_r  <= s2_sum;
    span_r      <= span_nxt;
    quo_r       <= quo_nxt;
    if (state_r == ST_CEVAL) begin
      avg_r      <= avg;
      chg_r      <= chg;
      kept_map_r <= kept_cur[MAP_W-1:0];
      dir_r      <= degen ? 1'b1 : cfg.direction_mask[tab];
      recip_r    <= recip(tab);
    end
    if (emit) begin
      out_r.channel      <= tab;
      out_r.mapped_value <= res_map;
      out_r.changed      <= chg_r;
      out_r.last         <= (cnt_r == LAST_CH);
    end
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

endmodule

### rtl/adc_window_average_deadband_map_top.sv
// top level: configuration registers, front, queue and back of the window average block
//
// Accumulates 16-bit converter samples per channel and, on a close request, reports
// every channel in ascending order: the windowed average (accumulator shifted right by
// window_shift) is compared against the last kept average with the channel's deadband;
// when it moves far enough it is clamped to the channel bounds and scaled to 0..16384,
// direct or inverted per direction_mask. Outside a close run sample requests are taken
// one per clock: the accumulator memory is read and written back in a two-stage pipeline
// with forwarding. A close run steps each channel through the memory read, the
// evaluation stage and, for a changed channel, a multiply by the channel's reciprocal
// span, and a result may wait on out_tready; requests keep entering the 4-deep queue
// during a run. Reset leaves no clearing pass.
module adc_window_average_deadband_map_top #(
  parameter int CHANNELS = 16,
  parameter int ACC_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,  // channel[3:0], sample[19:4], zero pad
  input  logic                            in_tuser,  // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata, // out_channel[3:0], mapped_value[18:4], zero pad
  output logic                            out_tuser, // changed
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [awadm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_wdata
);
  import awadm_pkg::*;

  awadm_cfg_t    cfg_r;
  awadm_push_t   push;
  awadm_head_t   head;
  logic          queue_full;
  logic          pop;
  logic          res_valid;
  awadm_result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_shift   <= WINDOW_SHIFT_RST;
      cfg_r.direction_mask <= DIRECTION_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SHIFT:   cfg_r.window_shift   <= cfg_wdata[SHIFT_W-1:0];
        REG_DIRECTION_MASK: cfg_r.direction_mask <= cfg_wdata[MASK_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  awadm_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .in_channel(in_tdata[3:0]),
    .in_sample (in_tdata[19:4]),
    .queue_full(queue_full),
    .push      (push)
  );

  awadm_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  awadm_back #(
    .CHANNELS(CHANNELS),
    .ACC_BITS(ACC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (head),
    .pop      (pop),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(out_tready)
  );

  // result channel
  assign out_tvalid = res_valid;
  assign out_tdata  = {5'b00000, res.mapped_value, res.channel};
  assign out_tuser  = res.changed;
  assign out_tlast  = res.last;

  // last flag only on the final channel of a run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[3:0] == 4'(CHANNELS - 1)))
    else $error("last flag on a channel other than the final one");

  // mapped value never exceeds full scale
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[18:4] <= FULL_SCALE))
    else $error("mapped value above full scale");

  // the front only queues requests that were accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    push.push |-> (in_tvalid && in_tready))
    else $error("queue push without an accepted input request");

endmodule

### tb/tb_adc_window_average_deadband_map_top.sv
// self-checking testbench for the window average, deadband and scaling block
module tb_adc_window_average_deadband_map_top;
  import awadm_pkg::*;

  localparam int NUM_CH          = 16;
  localparam int SETTLE_CYCLES   = 32;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 58;
  localparam int MAX_PRINTS      = 100;

  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // per-channel tables, entry 15 first
  localparam logic [16*16-1:0] DEADBAND_TAB = {
    16'd50, 16'd50, 16'd75, 16'd75, 16'd75, 16'd50, 16'd50, 16'd50,
    16'd75, 16'd75, 16'd50, 16'd50, 16'd50, 16'd50, 16'd50, 16'd50};
  localparam logic [16*16-1:0] LOW_TAB = {
    16'd450, 16'd450, 16'd1000, 16'd516, 16'd500, 16'd200, 16'd200, 16'd200,
    16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500, 16'd500};
  localparam logic [16*16-1:0] HIGH_TAB = {
    16'd65503, 16'd65503, 16'd62000, 16'd62000, 16'd62000, 16'd65500, 16'd65500, 16'd65500,
    16'd65500, 16'd65500, 16'd65500, 16'd65500, 16'd65500, 16'd65500, 16'd65500, 16'd65500};

  // window shift per random phase, phase 7 first
  localparam logic [PHASES*3-1:0] PHASE_SHIFTS = {
    3'd2, 3'd7, 3'd1, 3'd5, 3'd0, 3'd3, 3'd7, 3'd0};

  typedef struct {
    logic        action;
    logic [3:0]  channel;
    logic [15:0] sample;
    bit          typed;
    logic [14:0] t_mapped;
    bit          t_changed;
  } stim_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]          cfg_wdata  = '0;

  // predictor state
  logic [31:0]        win_acc  [NUM_CH];
  logic [15:0]        held_avg [NUM_CH];
  logic [MAP_W-1:0]   held_map [NUM_CH];
  logic [SHIFT_W-1:0] shift_reg;
  logic [MASK_W-1:0]  mask_reg;

  awadm_result_t channel_reports_due[$];
  stim_row_t     plan[$];
  int            mismatches     = 0;
  int            send_gap_pct   = 0;
  int            recv_stall_pct = 0;
  int            stall_cycles   = 0;

  adc_window_average_deadband_map_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch: %s", msg);
  endtask

  // clamp to the channel bounds and scale onto 0..full scale
  function automatic logic [MAP_W-1:0] scale_to_span(input int idx, input logic [15:0] avg,
                                                     input bit direct);
    int unsigned lo, hi, t, q;
    lo = LOW_TAB[idx*16 +: 16];
    hi = HIGH_TAB[idx*16 +: 16];
    if (hi <= lo) return '0;
    t = avg;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    q = ((hi - t) * FULL_SCALE) / (hi - lo);
    if (direct) return MAP_W'(q);
    return MAP_W'(FULL_SCALE - q);
  endfunction

  // close request: evaluate every channel in order and queue its report
  task automatic evaluate_window(input bit typed, input logic [14:0] t_map, input bit t_chg);
    awadm_result_t r;
    logic [15:0]   avg;
    int            a, k, d;
    bit            chg;
    for (int c = 0; c < NUM_CH; c++) begin
      avg = 16'(win_acc[c] >> shift_reg);
      a   = avg;
      k   = held_avg[c];
      d   = DEADBAND_TAB[c*16 +: 16];
      chg = (a <= k - d) || (a >= k + d);
      if (chg) begin
        held_avg[c] = avg;
        held_map[c] = scale_to_span(c, avg, mask_reg[c]);
      end
      win_acc[c]     = '0;
      r.channel      = CH_W'(c);
      r.mapped_value = typed ? t_map : held_map[c];
      r.changed      = typed ? t_chg : chg;
      r.last         = (c == NUM_CH - 1);
      channel_reports_due.push_back(r);
    end
  endtask

  // offer one request and update the predictor once it is taken
  task automatic send_request(input stim_row_t row);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= row.action;
    in_tdata  <= {4'b0000, row.sample, row.channel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (row.action == ACTION_SAMPLE)
      win_acc[row.channel] = win_acc[row.channel] + row.sample;
    else
      evaluate_window(row.typed, row.t_mapped, row.t_changed);
  endtask

  // drain outstanding reports, let the pipeline settle, then write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    in_tvalid <= 1'b0;
    while (channel_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_SHIFT) shift_reg = val[SHIFT_W-1:0];
    else if (idx == REG_DIRECTION_MASK) mask_reg = val;
  endtask

  function automatic stim_row_t mk_row(input logic action, input logic [3:0] ch,
                                       input logic [15:0] s, input bit typed = 0,
                                       input logic [14:0] t_map = '0, input bit t_chg = 0);
    stim_row_t r;
    r.action    = action;
    r.channel   = ch;
    r.sample    = s;
    r.typed     = typed;
    r.t_mapped  = t_map;
    r.t_changed = t_chg;
    return r;
  endfunction

  // sample value: mostly random, some aimed at the deadband edges
  function automatic logic [15:0] pick_sample(input int ch);
    int     roll, target, off, k, d;
    longint need;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      k      = held_avg[ch];
      d      = DEADBAND_TAB[ch*16 +: 16];
      off    = $urandom_range(0, 2);
      target = ($urandom_range(0, 1) ? k + d : k - d) + off - 1;
      need   = (longint'(target) <<< shift_reg) - longint'(win_acc[ch]);
      if (target >= 0 && target <= 65535 && need >= 0 && need <= 65535) return 16'(need);
      return 16'($urandom);
    end
    if (roll < 40) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (roll < 55) return 16'($urandom_range(0, 1023));
    return 16'($urandom);
  endfunction

  // result check and receiver backpressure
  always @(posedge clk) begin
    awadm_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (channel_reports_due.size() == 0) begin
        log_mismatch($sformatf("unexpected result ch %0d map %0d", out_tdata[3:0],
                               out_tdata[18:4]));
      end else begin
        want = channel_reports_due.pop_front();
        if (out_tdata[3:0] != want.channel || out_tdata[18:4] != want.mapped_value ||
            out_tuser != want.changed || out_tlast != want.last || out_tdata[23:19] != '0)
          log_mismatch($sformatf("ch %0d/%0d map %0d/%0d chg %0d/%0d last %0d/%0d pad %0h",
                                 out_tdata[3:0], want.channel, out_tdata[18:4],
                                 want.mapped_value, out_tuser, want.changed, out_tlast,
                                 want.last, out_tdata[23:19]));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("** adc_window_average_deadband_map_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    stim_row_t row;
    shift_reg = WINDOW_SHIFT_RST;
    mask_reg  = DIRECTION_MASK_RST;
    for (int c = 0; c < NUM_CH; c++) begin
      win_acc[c]  = '0;
      held_avg[c] = '0;
      held_map[c] = '0;
    end

    // directed rows at reset settings (shift 7)
    // close right after reset: nothing moves, all zero
    plan.push_back(mk_row(ACTION_CLOSE, 4'd0, 16'h0000, 1, 15'd0, 0));
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd0, 16'd6400));   // avg exactly kept + deadband
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd15, 16'hFFFF));
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd6, 16'd9600));   // wide deadband, on the edge
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd7, 16'd9472));   // one short of the edge
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd1, 16'd6272));   // one short of the edge
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd8, 16'hAAAA));
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd9, 16'h5555));
    plan.push_back(mk_row(ACTION_CLOSE, 4'd15, 16'hFFFF));   // close ignores channel and sample
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd0, 16'd12672));  // inside the band, kept
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd15, 16'hFFFF));
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd15, 16'hFFFF));
    plan.push_back(mk_row(ACTION_SAMPLE, 4'd6, 16'h0000));   // lower edge of the band
    plan.push_back(mk_row(ACTION_CLOSE, 4'd0, 16'h0000));
    plan.push_back(mk_row(ACTION_CLOSE, 4'd0, 16'h0000));    // back-to-back closes

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_request(plan[i]);

    // random phases, each with its own settings and idling
    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) write_reg(REG_SPARE_2, 16'($urandom));
      if (p == 5) write_reg(REG_SPARE_3, 16'($urandom));
      write_reg(REG_WINDOW_SHIFT, {13'($urandom), PHASE_SHIFTS[p*3 +: 3]});
      write_reg(REG_DIRECTION_MASK, (p == 0 || p == 6) ? 16'hFFFF :
                                    (p == 1 || p == 3) ? 16'h0000 : 16'($urandom));
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 58; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 58; end
        default: begin send_gap_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 11) == 0) begin
          row = mk_row(ACTION_CLOSE, 4'($urandom), 16'($urandom));
        end else begin
          row = mk_row(ACTION_SAMPLE, 4'($urandom), 16'h0000);
          row.sample = pick_sample(row.channel);
        end
        send_request(row);
      end
      row = mk_row(ACTION_CLOSE, 4'd0, 16'h0000);
      send_request(row);
    end

    // drain and finish
    in_tvalid <= 1'b0;
    while (channel_reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** adc_window_average_deadband_map_top: PASSED **");
    else
      $display("** adc_window_average_deadband_map_top: FAILED **");
    $finish;
  end

endmodule

### filelist.f
rtl/awadm_pkg.sv
rtl/awadm_front.sv
rtl/awadm_queue.sv
rtl/awadm_back.sv
rtl/adc_window_average_deadband_map_top.sv
tb/tb_adc_window_average_deadband_map_top.sv
